// ===== rtl/pawg_pkg.sv =====
// Shared constants, codes and the quarter-wave sine table of the waveform generator.
package pawg_pkg;

  // Command codes
  localparam logic [1:0] CMD_NEXT    = 2'd0;
  localparam logic [1:0] CMD_PEEK    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Wave type codes
  localparam logic [1:0] WAVE_SINE    = 2'd0;
  localparam logic [1:0] WAVE_SQUARE  = 2'd1;
  localparam logic [1:0] WAVE_SAW     = 2'd2;
  localparam logic [1:0] WAVE_PATTERN = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_WAVE_TYPE     = 3'd0;
  localparam logic [2:0] REG_PHASE_STEP    = 3'd1;
  localparam logic [2:0] REG_REPEAT_MODE   = 3'd2;
  localparam logic [2:0] REG_INVERT_OUTPUT = 3'd3;
  localparam logic [2:0] REG_STEP_PATTERN  = 3'd4;
  localparam logic [2:0] REG_WAVE_SCALE    = 3'd5;
  localparam logic [2:0] REG_WAVE_OFFSET   = 3'd6;

  // Reset value of the phase step register
  localparam logic [15:0] PHASE_STEP_RESET = 16'd1024;

  // Phase constants
  localparam logic [15:0] PHASE_END       = 16'hFFFF;
  localparam logic [15:0] PHASE_START_SIN = 16'hC000;
  localparam logic [15:0] PHASE_START_LIN = 16'h0000;
  localparam logic [13:0] QUARTER_MAX     = 14'h3FFF;

  // Wave shape constants
  localparam int SINE_TABLE_DEPTH = 64;
  localparam int SINE_ENTRIES     = 64;
  localparam int PATTERN_STEPS    = 16;
  localparam int PATTERN_BITS     = 16;

  // Serial step counts: one offset bit, then one multiplier bit per cycle
  localparam int PEEK_STEPS = 16;
  localparam int MUL_STEPS  = 18;

  // Quarter-wave sine magnitude in Q15
  function automatic logic [14:0] quarter_sine(input logic [5:0] idx);
    logic [14:0] m;
    case (idx)
      6'd0:  m = 15'd0;     6'd1:  m = 15'd804;   6'd2:  m = 15'd1608;  6'd3:  m = 15'd2410;
      6'd4:  m = 15'd3212;  6'd5:  m = 15'd4011;  6'd6:  m = 15'd4808;  6'd7:  m = 15'd5602;
      6'd8:  m = 15'd6393;  6'd9:  m = 15'd7179;  6'd10: m = 15'd7962;  6'd11: m = 15'd8739;
      6'd12: m = 15'd9512;  6'd13: m = 15'd10278; 6'd14: m = 15'd11039; 6'd15: m = 15'd11793;
      6'd16: m = 15'd12539; 6'd17: m = 15'd13279; 6'd18: m = 15'd14010; 6'd19: m = 15'd14732;
      6'd20: m = 15'd15446; 6'd21: m = 15'd16151; 6'd22: m = 15'd16846; 6'd23: m = 15'd17530;
      6'd24: m = 15'd18204; 6'd25: m = 15'd18868; 6'd26: m = 15'd19519; 6'd27: m = 15'd20159;
      6'd28: m = 15'd20787; 6'd29: m = 15'd21403; 6'd30: m = 15'd22005; 6'd31: m = 15'd22594;
      6'd32: m = 15'd23170; 6'd33: m = 15'd23731; 6'd34: m = 15'd24279; 6'd35: m = 15'd24811;
      6'd36: m = 15'd25329; 6'd37: m = 15'd25832; 6'd38: m = 15'd26319; 6'd39: m = 15'd26790;
      6'd40: m = 15'd27245; 6'd41: m = 15'd27683; 6'd42: m = 15'd28105; 6'd43: m = 15'd28510;
      6'd44: m = 15'd28898; 6'd45: m = 15'd29268; 6'd46: m = 15'd29621; 6'd47: m = 15'd29956;
      6'd48: m = 15'd30273; 6'd49: m = 15'd30571; 6'd50: m = 15'd30852; 6'd51: m = 15'd31113;
      6'd52: m = 15'd31356; 6'd53: m = 15'd31580; 6'd54: m = 15'd31785; 6'd55: m = 15'd31971;
      6'd56: m = 15'd32137; 6'd57: m = 15'd32285; 6'd58: m = 15'd32412; 6'd59: m = 15'd32521;
      6'd60: m = 15'd32609; 6'd61: m = 15'd32678; 6'd62: m = 15'd32728; 6'd63: m = 15'd32757;
      default: m = 15'd0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/phase_accumulator_waveform_generator.sv =====
// Phase-accumulator waveform generator with serial peek-ahead and serial scaling multiply.
//
// Each accepted transaction (next, peek or restart) yields exactly one sample. Next and
// restart go from acceptance to a registered result through S_WAVE, which forms the
// wave value from the phase, S_MUL, a shift-add multiply that consumes one bit of
// the widened wave value per cycle against wave_scale, and S_DONE, which adds wave_offset
// once the output register is free. Peek first runs S_PEEK, one bit of peek_offset per
// cycle, to form the look-ahead phase. One transaction is worked on at a time; a new one is
// accepted while the previous sample still waits in the output register.
module phase_accumulator_waveform_generator #(
  parameter int SINE_TABLE_DEPTH = pawg_pkg::SINE_TABLE_DEPTH,
  parameter int PATTERN_STEPS    = pawg_pkg::PATTERN_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // command channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [15:0]        peek_offset,
  // sample channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sample_value,
  output logic               wave_status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PEEK = 3'd1;
  localparam logic [2:0] S_WAVE = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam int CNT_W = $clog2(pawg_pkg::MUL_STEPS);
  localparam int SIN_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PAT_W = $clog2(PATTERN_STEPS + 1);

  // configuration registers
  logic [1:0]         wave_type;
  logic [15:0]        phase_step;
  logic               repeat_mode;
  logic               invert_output;
  logic [15:0]        step_pattern;
  logic [30:0]        wave_scale;
  logic signed [31:0] wave_offset;

  // working registers
  logic [2:0]         state;
  logic [15:0]        phase_accum;
  logic [15:0]        eval_phase;
  logic [CNT_W-1:0]   cnt;
  logic [15:0]        off_sr;
  logic [15:0]        peek_acc;
  logic               peek_ovf;
  logic [17:0]        mul_sr;
  logic signed [32:0] hacc;
  logic [1:0]         low2;

  // next values
  logic [15:0]        phase_adv_next;
  logic [17:0]        peek_sum;
  logic [15:0]        peek_acc_next;
  logic               peek_ovf_next;
  logic [16:0]        fut_sum;
  logic [15:0]        fut_phase_next;
  logic signed [15:0] wave_val;
  logic signed [17:0] mul_w_next;
  logic signed [32:0] addend;
  logic signed [32:0] mul_sum;
  logic [31:0]        mid_word;
  logic               is_end;

  // wave shape helpers
  logic [1:0]                quad;
  logic [13:0]               qa;
  logic [14+SIN_W-1:0]       sin_prod;
  logic [SIN_W-1:0]          sin_idx_w;
  logic [5:0]                sin_idx;
  logic signed [15:0]        sin_mag;
  logic [16+PAT_W-1:0]       pat_prod;
  logic [PAT_W-1:0]          pat_step;
  logic [PAT_W-1:0]          pat_bit;
  logic                      pat_on;
  logic [16:0]               adv_sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign is_end    = (phase_accum == pawg_pkg::PHASE_END) && !repeat_mode;

  // Advance the phase by one step, wrapping or saturating
  always_comb begin
    adv_sum = {1'b0, phase_accum} + {1'b0, phase_step};
    if (repeat_mode || !adv_sum[16]) begin
      phase_adv_next = adv_sum[15:0];
    end else begin
      phase_adv_next = pawg_pkg::PHASE_END;
    end
  end

  // Peek: double the partial product and add the step on a set offset bit, MSB first
  always_comb begin
    peek_sum       = {1'b0, peek_acc, 1'b0} + (off_sr[15] ? {2'b00, phase_step} : 18'd0);
    peek_acc_next  = peek_sum[15:0];
    peek_ovf_next  = peek_ovf | (peek_sum[17:16] != 2'b00);
    fut_sum        = {1'b0, peek_acc_next} + {1'b0, phase_accum};
    if (repeat_mode || !(peek_ovf_next || fut_sum[16])) begin
      fut_phase_next = fut_sum[15:0];
    end else begin
      fut_phase_next = pawg_pkg::PHASE_END;
    end
  end

  // Form the Q15 wave value at the evaluated phase
  always_comb begin
    quad = eval_phase[15:14];
    qa   = quad[0] ? (pawg_pkg::QUARTER_MAX - eval_phase[13:0]) : eval_phase[13:0];
    sin_prod  = {{SIN_W{1'b0}}, qa} * (14+SIN_W)'(SINE_TABLE_DEPTH);
    sin_idx_w = sin_prod[14+SIN_W-1:14];
    if (32'(sin_idx_w) > 32'(pawg_pkg::SINE_ENTRIES - 1)) begin
      sin_idx = 6'(pawg_pkg::SINE_ENTRIES - 1);
    end else begin
      sin_idx = 6'(sin_idx_w);
    end
    sin_mag = signed'({1'b0, pawg_pkg::quarter_sine(sin_idx)});

    pat_prod = {{PAT_W{1'b0}}, eval_phase} * (16+PAT_W)'(PATTERN_STEPS);
    pat_step = pat_prod[16+PAT_W-1:16];
    pat_bit  = PAT_W'(PATTERN_STEPS - 1) - pat_step;
    pat_on   = (32'(pat_bit) < 32'(pawg_pkg::PATTERN_BITS)) &&
               step_pattern[pat_bit[3:0]];

    case (wave_type)
      pawg_pkg::WAVE_SINE:    wave_val = quad[1] ? -sin_mag : sin_mag;
      pawg_pkg::WAVE_SQUARE:  wave_val = eval_phase[15] ? 16'sd32767 : -16'sd32768;
      pawg_pkg::WAVE_SAW:     wave_val = signed'({~eval_phase[15], eval_phase[14:0]});
      default:                wave_val = pat_on ? 16'sd32767 : -16'sd32768;
    endcase

    // widen to signed Q1.16 (18 bits) and optionally negate
    if (invert_output) begin
      mul_w_next = -{{1{wave_val[15]}}, wave_val, 1'b0};
    end else begin
      mul_w_next = {{1{wave_val[15]}}, wave_val, 1'b0};
    end
  end

  // Multiply step: add +/- scale on the current bit, the sign bit weighs negative
  always_comb begin
    if (!mul_sr[0]) begin
      addend = 33'sd0;
    end else if (cnt == CNT_W'(pawg_pkg::MUL_STEPS - 1)) begin
      addend = -signed'({2'b00, wave_scale});
    end else begin
      addend = signed'({2'b00, wave_scale});
    end
    mul_sum  = hacc + addend;
    mid_word = {hacc[29:0], low2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      phase_accum   <= 16'd0;
      wave_type     <= pawg_pkg::WAVE_SINE;
      phase_step    <= pawg_pkg::PHASE_STEP_RESET;
      repeat_mode   <= 1'b1;
      invert_output <= 1'b0;
      step_pattern  <= 16'd0;
      wave_scale    <= 31'd0;
      wave_offset   <= 32'sd0;
    end else begin
      // take configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          pawg_pkg::REG_WAVE_TYPE:     wave_type     <= cfg_data[1:0];
          pawg_pkg::REG_PHASE_STEP:    phase_step    <= cfg_data[15:0];
          pawg_pkg::REG_REPEAT_MODE:   repeat_mode   <= cfg_data[0];
          pawg_pkg::REG_INVERT_OUTPUT: invert_output <= cfg_data[0];
          pawg_pkg::REG_STEP_PATTERN:  step_pattern  <= cfg_data[15:0];
          pawg_pkg::REG_WAVE_SCALE:    wave_scale    <= cfg_data[30:0];
          pawg_pkg::REG_WAVE_OFFSET:   wave_offset   <= signed'(cfg_data);
          default: ;
        endcase
      end

      // drop a delivered sample unless a new one is loaded in its place
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (cmd)
              pawg_pkg::CMD_NEXT: begin
                eval_phase <= phase_accum;
                if (!is_end) begin
                  phase_accum <= phase_adv_next;
                end
                state <= S_WAVE;
              end
              pawg_pkg::CMD_RESTART: begin
                if (wave_type == pawg_pkg::WAVE_SINE || wave_type == pawg_pkg::WAVE_SQUARE) begin
                  phase_accum <= pawg_pkg::PHASE_START_SIN;
                  eval_phase  <= pawg_pkg::PHASE_START_SIN;
                end else begin
                  phase_accum <= pawg_pkg::PHASE_START_LIN;
                  eval_phase  <= pawg_pkg::PHASE_START_LIN;
                end
                state <= S_WAVE;
              end
              default: begin
                // peek, and the unused code as peek with no offset
                off_sr   <= (cmd == pawg_pkg::CMD_PEEK) ? peek_offset : 16'd0;
                peek_acc <= 16'd0;
                peek_ovf <= 1'b0;
                cnt      <= '0;
                state    <= S_PEEK;
              end
            endcase
          end
        end
        S_PEEK: begin
          peek_acc <= peek_acc_next;
          peek_ovf <= peek_ovf_next;
          off_sr   <= {off_sr[14:0], 1'b0};
          cnt      <= cnt + 1'b1;
          if (cnt == CNT_W'(pawg_pkg::PEEK_STEPS - 1)) begin
            eval_phase <= fut_phase_next;
            state      <= S_WAVE;
          end
        end
        S_WAVE: begin
          mul_sr <= mul_w_next;
          hacc   <= 33'sd0;
          low2   <= 2'b00;
          cnt    <= '0;
          state  <= S_MUL;
        end
        S_MUL: begin
          hacc   <= mul_sum >>> 1;
          low2   <= {mul_sum[0], low2[1]};
          mul_sr <= {1'b0, mul_sr[17:1]};
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(pawg_pkg::MUL_STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            sample_value <= signed'(mid_word + $unsigned(wave_offset));
            wave_status  <= (eval_phase == pawg_pkg::PHASE_END) && !repeat_mode;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
